// ===== design/snce_pkg.sv =====
// ----------------------------------------------------------------------------
// SPI NOR command engine package
// Shared constants, register map, control types and opcode decode.
// ----------------------------------------------------------------------------
package snce_pkg;

    localparam int unsigned FLASH_SIZE_DEF  = 2097152;
    localparam int unsigned SECTOR_SIZE_DEF = 4096;

    localparam int WORD_AW = 7;

    localparam logic [8:0] OFF_CDCTL0 = 9'h070;
    localparam logic [8:0] OFF_INTC   = 9'h194;

    localparam logic [WORD_AW-1:0] W_CDCTL0 = 7'h1C;
    localparam logic [WORD_AW-1:0] W_CDT    = 7'h20;
    localparam logic [WORD_AW-1:0] W_ADDR   = 7'h21;
    localparam logic [WORD_AW-1:0] W_D0     = 7'h22;
    localparam logic [WORD_AW-1:0] W_D1     = 7'h23;
    localparam logic [WORD_AW-1:0] W_INTS   = 7'h64;

    localparam logic [7:0] OP_RDID = 8'h9F;
    localparam logic [7:0] OP_RDSR = 8'h05;
    localparam logic [7:0] OP_READ = 8'h03;
    localparam logic [7:0] OP_PP   = 8'h02;
    localparam logic [7:0] OP_SE   = 8'h20;

    localparam logic [7:0]  ERASED     = 8'hFF;
    localparam logic [31:0] JEDEC_WORD = 32'h001A5A9D;
    localparam logic [31:0] STATUS_WEL = 32'h0000_0002;

    localparam logic [1:0] CS_ONE = 2'd1;
    localparam logic [1:0] CS_TWO = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // bus transfer taken this cycle
        logic load_rd;  // capture the window read word
        logic exec;     // start a flash command
        logic fl_cap;   // capture one flash byte for a read
        logic pp_wr;    // AND one byte into flash
        logic er_wr;    // write one erased byte (erase or reset clear)
        logic finish;   // commit command results and completion
        logic push;     // move the pending result to the output register
    } snce_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       is_read;
        logic       start;
        logic [7:0] op;
        logic [3:0] n;
        logic       last;
        logic       er_last;
        logic       base_ok;
    } snce_stat_t;

    function automatic logic [7:0] opcode_of(input logic [31:0] cdt);
        logic [7:0] op;
        op = 8'h00;
        if (cdt[1:0] == CS_ONE)
        begin
            op = cdt[31:24];
        end
        else if (cdt[1:0] == CS_TWO)
        begin
            op = cdt[23:16];
        end
        return op;
    endfunction

endpackage

// ===== design/snce_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module snce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/snce_ctrl.sv =====
// ----------------------------------------------------------------------------
// SPI NOR command engine controller
// Sequences bus transfers, flash commands, erase and the reset clear pass.
// ----------------------------------------------------------------------------
module snce_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  snce_pkg::snce_stat_t stat,
    output snce_pkg::snce_cmd_t  cmd
);
    import snce_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD_WAIT, ST_EXEC, ST_FRD_REQ, ST_FRD_CAP,
        ST_PP_REQ, ST_PP_WR, ST_ERASE, ST_FINISH, ST_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.er_wr = 1'b1;
                if (stat.er_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.is_read)
                    begin
                        state_next = ST_RD_WAIT;
                    end
                    else if (stat.start)
                    begin
                        state_next = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RD_WAIT:
            begin
                cmd.load_rd = 1'b1;
                state_next  = ST_RESP;
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                case (stat.op)
                    OP_READ: state_next = (stat.n == 4'd0) ? ST_FINISH : ST_FRD_REQ;
                    OP_PP:   state_next = (stat.n == 4'd0) ? ST_FINISH : ST_PP_REQ;
                    OP_SE:   state_next = stat.base_ok ? ST_ERASE : ST_FINISH;
                    default: state_next = ST_FINISH;
                endcase
            end
            ST_FRD_REQ:
            begin
                state_next = ST_FRD_CAP;
            end
            ST_FRD_CAP:
            begin
                cmd.fl_cap = 1'b1;
                state_next = stat.last ? ST_FINISH : ST_FRD_REQ;
            end
            ST_PP_REQ:
            begin
                state_next = ST_PP_WR;
            end
            ST_PP_WR:
            begin
                cmd.pp_wr  = 1'b1;
                state_next = stat.last ? ST_FINISH : ST_PP_REQ;
            end
            ST_ERASE:
            begin
                cmd.er_wr = 1'b1;
                if (stat.er_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.push      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== design/snce_dp.sv =====
// ----------------------------------------------------------------------------
// SPI NOR command engine datapath
// Register window, command slot registers, flash array and byte counters.
// ----------------------------------------------------------------------------
module snce_dp #(
    parameter int unsigned FLASH_SIZE  = snce_pkg::FLASH_SIZE_DEF,
    parameter int unsigned SECTOR_SIZE = snce_pkg::SECTOR_SIZE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_mode,
    input  logic [8:0]           in_offset,
    input  logic [31:0]          in_wdata,
    input  snce_pkg::snce_cmd_t  cmd,
    output snce_pkg::snce_stat_t stat,
    output logic [31:0]          out_data
);
    import snce_pkg::*;

    localparam int FAW = $clog2(FLASH_SIZE);
    localparam int SB  = $clog2(SECTOR_SIZE);
    localparam logic [32:0] FSIZE = 33'(FLASH_SIZE);
    localparam logic [32:0] SSIZE = 33'(SECTOR_SIZE);

    logic [31:0] cdctl0_reg, cdt_reg, addr_reg, d0_reg, d1_reg, ints_reg;
    logic [31:0] res_reg, out_reg;
    logic [127:0] wvalid_reg;
    logic         rvalid_reg;
    logic [WORD_AW-1:0] wi_reg;
    logic [2:0]   cnt_reg;
    logic [63:0]  dbuf_reg;
    logic [FAW-1:0] er_reg;
    logic [32:0]  er_end_reg;

    logic [WORD_AW-1:0] wi;
    logic        special, win_we;
    logic [31:0] win_q, rd_word;
    logic [32:0] fa, base, endc;
    logic        in_rng;
    logic [63:0] dpair;
    logic [7:0]  fq, dbyte, fwd;
    logic [FAW-1:0] faddr;
    logic        fwe;
    logic [3:0]  n;

    assign wi      = in_offset[8:2];
    assign special = (wi == W_CDCTL0) || (wi == W_CDT) || (wi == W_ADDR)
                  || (wi == W_D0) || (wi == W_D1) || (wi == W_INTS);
    assign win_we  = cmd.accept && in_mode && (in_offset != OFF_INTC) && !special;

    snce_ram #(.WIDTH(32), .DEPTH(128)) u_win (
        .clk(clk), .we(win_we), .addr(wi), .wdata(in_wdata), .rdata(win_q)
    );

    // Flash byte address of the current command byte, without wrap.
    assign fa     = {1'b0, addr_reg} + {30'b0, cnt_reg};
    assign in_rng = fa < FSIZE;
    assign base   = {1'b0, addr_reg[31:SB], {SB{1'b0}}};
    assign endc   = ((base + SSIZE) > FSIZE) ? FSIZE : (base + SSIZE);
    assign dpair  = {d1_reg, d0_reg};
    assign dbyte  = dpair[{cnt_reg, 3'b000} +: 8];
    assign faddr  = cmd.er_wr ? er_reg : fa[FAW-1:0];
    assign fwe    = cmd.er_wr || (cmd.pp_wr && in_rng);
    assign fwd    = cmd.er_wr ? ERASED : (fq & dbyte);

    snce_ram #(.WIDTH(8), .DEPTH(FLASH_SIZE)) u_flash (
        .clk(clk), .we(fwe), .addr(faddr), .wdata(fwd), .rdata(fq)
    );

    assign n = (cdt_reg[8] && (cdt_reg[7:5] != 3'd0)) ? 4'd8 : cdt_reg[8:5];

    always_comb
    begin
        priority case (wi_reg)
            W_CDCTL0: rd_word = cdctl0_reg;
            W_CDT:    rd_word = cdt_reg;
            W_ADDR:   rd_word = addr_reg;
            W_D0:     rd_word = d0_reg;
            W_D1:     rd_word = d1_reg;
            W_INTS:   rd_word = ints_reg;
            default:  rd_word = rvalid_reg ? win_q : 32'd0;
        endcase
    end

    always_comb
    begin
        stat.is_read = !in_mode;
        stat.start   = in_mode && (in_offset == OFF_CDCTL0) && in_wdata[0];
        stat.op      = opcode_of(cdt_reg);
        stat.n       = n;
        stat.last    = ({1'b0, cnt_reg} == (n - 4'd1));
        stat.er_last = (({{(33-FAW){1'b0}}, er_reg} + 33'd1) >= er_end_reg);
        stat.base_ok = base < FSIZE;
    end

    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cdctl0_reg <= '0;
            cdt_reg    <= '0;
            addr_reg   <= '0;
            d0_reg     <= '0;
            d1_reg     <= '0;
            ints_reg   <= '0;
            wvalid_reg <= '0;
            er_reg     <= '0;
            er_end_reg <= FSIZE;
        end
        else
        begin
            if (cmd.accept && in_mode)
            begin
                if (in_offset == OFF_INTC)
                begin
                    ints_reg <= ints_reg & ~in_wdata;
                end
                else
                begin
                    priority case (wi)
                        W_CDCTL0: cdctl0_reg <= in_wdata;
                        W_CDT:    cdt_reg    <= in_wdata;
                        W_ADDR:   addr_reg   <= in_wdata;
                        W_D0:     d0_reg     <= in_wdata;
                        W_D1:     d1_reg     <= in_wdata;
                        W_INTS:   ints_reg   <= in_wdata;
                        default:  wvalid_reg[wi] <= 1'b1;
                    endcase
                end
            end
            if (cmd.exec && stat.base_ok)
            begin
                er_reg     <= base[FAW-1:0];
                er_end_reg <= endc;
            end
            if (cmd.er_wr)
            begin
                er_reg <= er_reg + FAW'(1);
            end
            if (cmd.finish)
            begin
                ints_reg[0]   <= 1'b1;
                cdctl0_reg[0] <= 1'b0;
                case (stat.op)
                    OP_RDID: d0_reg <= JEDEC_WORD;
                    OP_RDSR: d0_reg <= STATUS_WEL;
                    OP_READ:
                    begin
                        d0_reg <= dbuf_reg[31:0];
                        d1_reg <= dbuf_reg[63:32];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            wi_reg     <= wi;
            rvalid_reg <= wvalid_reg[wi];
            res_reg    <= 32'd0;
        end
        if (cmd.load_rd)
        begin
            res_reg <= rd_word;
        end
        if (cmd.exec)
        begin
            cnt_reg  <= 3'd0;
            dbuf_reg <= 64'd0;
        end
        if (cmd.fl_cap)
        begin
            dbuf_reg[{cnt_reg, 3'b000} +: 8] <= in_rng ? fq : ERASED;
        end
        if (cmd.fl_cap || cmd.pp_wr)
        begin
            cnt_reg <= cnt_reg + 3'd1;
        end
        if (cmd.push)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

// ===== design/spi_nor_command_engine.sv =====
// ----------------------------------------------------------------------------
// SPI NOR command engine
// Register window with a manual-command engine in front of a NOR flash array.
// ----------------------------------------------------------------------------
// Each transfer on the s_ channel is one 32-bit bus access: s_tuser is the
// access kind (0 read, 1 write) and s_tdata carries the byte offset and the
// write data. Every access returns exactly one word on the m_ channel: the
// window word for a read and zero for a write.
// A read passes a wait state before the response (window RAM has a
// registered read), a plain write goes straight to it. A write of CDCTL0
// with TRREQ set runs the command in the slot: a byte read or page program
// takes each byte through a flash read state, then a capture or write state,
// for up to eight bytes, ID and status reads load a fixed word, and a sector
// erase writes the sector byte by byte through the single flash write port.
// The block works on one access at a time, but a new access is accepted
// while the previous result still sits in the output register.
// After reset the flash array is set to 0xFF by a clearing pass over every
// flash byte; s_tready stays low until it ends. If the receiver
// stalls, the finished result waits in the state before the output
// register and no further access is taken until it moves.
// ----------------------------------------------------------------------------
module spi_nor_command_engine #(
    parameter int unsigned FLASH_SIZE  = snce_pkg::FLASH_SIZE_DEF,
    parameter int unsigned SECTOR_SIZE = snce_pkg::SECTOR_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // offset[8:0], write_data[40:9], zero pad
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // read_data[31:0]
);
    import snce_pkg::*;

    snce_cmd_t  cmd;
    snce_stat_t stat;

    // The controller owns sequencing and the handshake.
    snce_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .stat(stat), .cmd(cmd)
    );

    // The datapath holds the window, the flash array and the result.
    snce_dp #(.FLASH_SIZE(FLASH_SIZE), .SECTOR_SIZE(SECTOR_SIZE)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_mode(s_tuser), .in_offset(s_tdata[8:0]), .in_wdata(s_tdata[40:9]),
        .cmd(cmd), .stat(stat), .out_data(m_tdata)
    );

    // One access in flight: after a transfer the engine is busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("access accepted while busy");

    // The clearing pass and erase never overlap bus handshakes.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.er_wr |-> !s_tready)
        else $error("erase write while idle");

    // A result is pushed only into a free or draining output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> m_tvalid)
        else $error("pushed result not presented");

endmodule

// ===== dv/tb_spi_nor_command_engine.sv =====
// ----------------------------------------------------------------------------
// SPI NOR command engine testbench
// Drives register reads, writes and flash commands through the stream ports
// and checks every returned word against an in-bench model of the window and
// the flash array. A directed table comes first, then random command traffic.
// ----------------------------------------------------------------------------
module tb_spi_nor_command_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import snce_pkg::*;

    localparam int unsigned FSIZE = FLASH_SIZE_DEF;
    localparam int unsigned SSIZE = SECTOR_SIZE_DEF;
    localparam int ITEMS = 900;
    // The limit allows for the clearing pass over the whole flash and for sector erases.
    localparam longint CYCLE_LIMIT = 64'd4 * FSIZE + 64'd40 * ITEMS * SSIZE / 4 + 64'd200000;

    localparam logic MODE_RD = 1'b0;
    localparam logic MODE_WR = 1'b1;
    localparam logic [8:0] OFF_CDT  = 9'h080;
    localparam logic [8:0] OFF_ADDR = 9'h084;
    localparam logic [8:0] OFF_D0   = 9'h088;
    localparam logic [8:0] OFF_D1   = 9'h08C;
    localparam logic [8:0] OFF_INTS = 9'h190;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // offset[8:0], write_data[40:9], zero pad
    logic        s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // read_data[31:0]

    spi_nor_command_engine uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow of the register window and the flash array.
    logic [31:0] shadow_win [128];
    logic [7:0]  shadow_flash [FSIZE];
    logic [31:0] expected_words [$];
    int          error_count;
    longint      cycle_count;
    bit          stim_done;

    typedef struct {
        logic        mode;
        logic [8:0]  off;
        logic [31:0] wdata;
        bit          has_fixed;
        logic [31:0] fixed;
    } access_row_t;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %08h expected %08h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Runs the command currently described by the slot words.
    function automatic void run_flash_command();
        logic [31:0] cdt;
        logic [31:0] addr;
        logic [7:0]  op;
        logic [63:0] dbuf;
        longint      a;
        longint      base;
        longint      stop;
        int          nbytes;
        cdt = shadow_win[W_CDT];
        addr = shadow_win[W_ADDR];
        nbytes = cdt[8:5];
        if (nbytes > 8)
        begin
            nbytes = 8;
        end
        op = 8'h00;
        if (cdt[1:0] == CS_ONE)
        begin
            op = cdt[31:24];
        end
        else if (cdt[1:0] == CS_TWO)
        begin
            op = cdt[23:16];
        end
        case (op)
            OP_RDID: shadow_win[W_D0] = JEDEC_WORD;
            OP_RDSR: shadow_win[W_D0] = STATUS_WEL;
            OP_READ:
            begin
                dbuf = '0;
                for (int i = 0; i < nbytes; i++)
                begin
                    a = longint'(addr) + i;
                    dbuf[i*8 +: 8] = (a < FSIZE) ? shadow_flash[a] : ERASED;
                end
                shadow_win[W_D0] = dbuf[31:0];
                shadow_win[W_D1] = dbuf[63:32];
            end
            OP_PP:
            begin
                dbuf = {shadow_win[W_D1], shadow_win[W_D0]};
                for (int i = 0; i < nbytes; i++)
                begin
                    a = longint'(addr) + i;
                    if (a < FSIZE)
                    begin
                        shadow_flash[a] &= dbuf[i*8 +: 8];
                    end
                end
            end
            OP_SE:
            begin
                base = longint'(addr) - (longint'(addr) % SSIZE);
                stop = base + SSIZE;
                if (base < FSIZE)
                begin
                    if (stop > FSIZE)
                    begin
                        stop = FSIZE;
                    end
                    for (longint j = base; j < stop; j++)
                    begin
                        shadow_flash[j] = ERASED;
                    end
                end
            end
            default: ;
        endcase
        shadow_win[W_INTS] |= 32'd1;
    endfunction

    // Applies one bus access to the shadow and returns the word it reads.
    function automatic logic [31:0] bus_access_word(input logic mode, input logic [8:0] off,
                                                    input logic [31:0] wdata);
        logic [6:0] w;
        w = off[8:2];
        if (mode == MODE_RD)
        begin
            return shadow_win[w];
        end
        if (off == OFF_INTC)
        begin
            shadow_win[W_INTS] &= ~wdata;
            return 32'd0;
        end
        shadow_win[w] = wdata;
        if (off == OFF_CDCTL0 && wdata[0])
        begin
            run_flash_command();
            shadow_win[w][0] = 1'b0;
        end
        return 32'd0;
    endfunction

    // Starts and ends at a falling edge; s_tvalid stays high into the next
    // access when that one has no idle gap.
    task automatic send_access(input logic mode, input logic [8:0] off,
                               input logic [31:0] wdata, input bit has_fixed,
                               input logic [31:0] fixed);
        logic [31:0] predicted;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {7'd0, wdata, off};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = bus_access_word(mode, off, wdata);
        if (has_fixed && predicted !== fixed)
        begin
            report_mismatch("table entry", predicted, fixed);
        end
        expected_words.push_back(predicted);
        @(negedge clk);
    endtask

    task automatic do_cmd(input logic [31:0] cdt, input logic [31:0] addr);
        send_access(MODE_WR, OFF_CDT, cdt, 1'b0, '0);
        send_access(MODE_WR, OFF_ADDR, addr, 1'b0, '0);
        send_access(MODE_WR, OFF_CDCTL0, $urandom | 32'd1, 1'b0, '0);
    endtask

    function automatic logic [31:0] make_cdt(input logic [1:0] cs, input logic [7:0] op,
                                             input logic [3:0] n);
        logic [31:0] c;
        c = $urandom;
        c[1:0] = cs;
        c[8:5] = n;
        if (cs == CS_ONE)
        begin
            c[31:24] = op;
        end
        else if (cs == CS_TWO)
        begin
            c[23:16] = op;
        end
        return c;
    endfunction

    // Flash addresses are kept in a small set of hot sectors so that reads
    // find programmed data, with a few near and past the end of the array.
    function automatic logic [31:0] pick_addr();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
        begin
            return $urandom;
        end
        if (r == 1)
        begin
            return FSIZE - $urandom_range(1, 10);
        end
        return $urandom_range(0, 3) * SSIZE + $urandom_range(0, 63) +
               ($urandom_range(0, 1) ? SSIZE - 64 : 0);
    endfunction

    // Receiver: random stalls, then compare with the oldest expectation.
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
            begin
                @(posedge clk);
            end
            if (expected_words.size() == 0)
            begin
                report_mismatch("unexpected result", m_tdata, 32'd0);
            end
            else if (m_tdata !== expected_words[0])
            begin
                report_mismatch("read_data", m_tdata, expected_words.pop_front());
            end
            else
            begin
                void'(expected_words.pop_front());
            end
            @(negedge clk);
        end
    end

    // Watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        access_row_t rows [$];
        int r;
        logic [8:0] off;
        cycle_count = 0;
        error_count = 0;
        stim_done = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = MODE_RD;
        s_tdata = '0;
        for (int i = 0; i < 128; i++)
        begin
            shadow_win[i] = '0;
        end
        for (int i = 0; i < FSIZE; i++)
        begin
            shadow_flash[i] = ERASED;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: fixed expectations only where obvious.
        rows = '{
            '{MODE_RD, 9'h000, 32'h0, 1, 32'h0},
            '{MODE_RD, 9'h1FF, 32'h0, 1, 32'h0},
            '{MODE_WR, 9'h1FC, 32'hFFFF_FFFF, 1, 32'h0},
            '{MODE_RD, 9'h1FD, 32'h0, 1, 32'hFFFF_FFFF},
            '{MODE_WR, OFF_CDT, {OP_RDID, 8'h00, 16'h0001}, 1, 32'h0},
            '{MODE_WR, OFF_CDCTL0, 32'h1, 1, 32'h0},
            '{MODE_RD, OFF_D0, 32'h0, 1, JEDEC_WORD},
            '{MODE_RD, OFF_CDCTL0, 32'h0, 1, 32'h0},
            '{MODE_RD, OFF_INTS, 32'h0, 1, 32'h1},
            '{MODE_WR, OFF_INTC, 32'h1, 1, 32'h0},
            '{MODE_RD, OFF_INTS, 32'h0, 1, 32'h0},
            '{MODE_WR, OFF_CDT, {8'h00, OP_RDSR, 16'h0002}, 1, 32'h0},
            '{MODE_WR, OFF_CDCTL0, 32'hFFFF_FFFF, 1, 32'h0},
            '{MODE_RD, OFF_D0, 32'h0, 1, STATUS_WEL},
            '{MODE_RD, OFF_CDCTL0, 32'h0, 1, 32'hFFFF_FFFE},
            '{MODE_WR, OFF_D0, 32'h1234_5678, 0, 32'h0},
            '{MODE_WR, OFF_D1, 32'h9ABC_DEF0, 0, 32'h0},
            '{MODE_WR, OFF_ADDR, FSIZE - 4, 0, 32'h0},
            // Page program with data size fifteen, clamped to eight bytes, half past the end.
            '{MODE_WR, OFF_CDT, {OP_PP, 8'h00, 16'h01E1}, 0, 32'h0},
            '{MODE_WR, OFF_CDCTL0, 32'h1, 0, 32'h0},
            // Byte read of the same range back.
            '{MODE_WR, OFF_CDT, {8'h00, OP_READ, 16'h01E2}, 0, 32'h0},
            '{MODE_WR, OFF_CDCTL0, 32'h1, 0, 32'h0},
            '{MODE_RD, OFF_D1, 32'h0, 1, 32'hFFFF_FFFF},
            // Command size three is a no-op; TRREQ clear only stores.
            '{MODE_WR, OFF_CDT, {OP_SE, OP_SE, 16'h0003}, 0, 32'h0},
            '{MODE_WR, OFF_CDCTL0, 32'h1, 0, 32'h0},
            '{MODE_WR, OFF_CDCTL0, 32'hFFFF_FFFE, 0, 32'h0},
            '{MODE_WR, 9'h071, 32'h1, 0, 32'h0},
            '{MODE_WR, 9'h195, 32'hFFFF_FFFF, 0, 32'h0}
        };
        foreach (rows[i])
        begin
            send_access(rows[i].mode, rows[i].off, rows[i].wdata, rows[i].has_fixed,
                        rows[i].fixed);
        end
        // Erase of the last sector and one past the array.
        do_cmd(make_cdt(CS_ONE, OP_SE, 4'd0), FSIZE - 1);
        do_cmd(make_cdt(CS_TWO, OP_SE, 4'd0), 32'hFFFF_FFFF);
        do_cmd(make_cdt(CS_ONE, OP_READ, 4'd8), FSIZE - 4);

        // Random part: mostly command sequences with random content.
        for (int k = 0; k < ITEMS; )
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                logic [7:0] op;
                logic [1:0] cs;
                case ($urandom_range(0, 9))
                    0: op = OP_RDID;
                    1: op = OP_RDSR;
                    2, 3, 4: op = OP_READ;
                    5, 6: op = OP_PP;
                    7: op = ($urandom_range(0, 5) == 0) ? OP_SE : OP_READ;
                    default: op = 8'($urandom);
                endcase
                cs = ($urandom_range(0, 9) == 0) ? 2'($urandom) : ($urandom_range(0, 1) ?
                     CS_ONE : CS_TWO);
                if (op == OP_PP)
                begin
                    send_access(MODE_WR, OFF_D0, $urandom, 1'b0, '0);
                    send_access(MODE_WR, OFF_D1, $urandom, 1'b0, '0);
                    k += 2;
                end
                do_cmd(make_cdt(cs, op, 4'($urandom)), pick_addr());
                send_access(MODE_RD, $urandom_range(0, 1) ? OFF_D0 : OFF_D1, $urandom, 1'b0,
                            '0);
                k += 4;
            end
            else if (r < 65)
            begin
                send_access(MODE_WR, OFF_INTC, $urandom, 1'b0, '0);
                k++;
            end
            else
            begin
                off = 9'($urandom);
                // Rarely hit CDCTL0 with noise, which may run a command.
                if (off == OFF_CDCTL0 && $urandom_range(0, 1))
                begin
                    off = OFF_INTS;
                end
                send_access(1'($urandom_range(0, 1)), off, $urandom, 1'b0, '0);
                k++;
            end
        end
        s_tvalid <= 1'b0;

        while (expected_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// ===== files.f =====
design/snce_pkg.sv
design/snce_ram.sv
design/snce_ctrl.sv
design/snce_dp.sv
design/spi_nor_command_engine.sv
dv/tb_spi_nor_command_engine.sv
